@@ hw/rtl/gpc_pkg.sv @@
// shared types and constants for the grid path count block
`default_nettype none
package gpc_pkg;

  localparam int COUNT_W  = 30;
  localparam int SUM_W    = 9;
  localparam int CODE_W   = 2;
  localparam int GRID_W   = 7;

  localparam int MAX_SIDE_DEF = 64;

  localparam logic [GRID_W-1:0]  GRID_RESET = GRID_W'(64);
  localparam logic [COUNT_W:0]   COUNT_MOD  = (COUNT_W+1)'(1000000007);
  localparam logic [SUM_W-1:0]   SUM_LIMIT  = SUM_W'(511);

  // bit positions of the exit directions inside a cell code
  localparam int EXIT_RIGHT_BIT = 0;
  localparam int EXIT_DOWN_BIT  = 1;

  typedef struct packed {
    logic               reach;
    logic [CODE_W-1:0]  code;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } line_entry_t;

  typedef struct packed {
    logic first;
    logic has_above;
    logic has_left;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/gpc_line_buf.sv @@
// line store holding the results of the row above, registered read
`default_nettype none
module gpc_line_buf #(
  parameter int DEPTH  = gpc_pkg::MAX_SIDE_DEF,
  parameter int ADDR_W = 6
) (
  input  wire                        clk,
  input  wire                        rd_en,
  input  wire [ADDR_W-1:0]           rd_addr,
  output gpc_pkg::line_entry_t       rd_data,
  input  wire                        wr_en,
  input  wire [ADDR_W-1:0]           wr_addr,
  input  wire gpc_pkg::line_entry_t  wr_data
);
  import gpc_pkg::*;

  line_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/gpc_cell.sv @@
// per-cell update: path count mod p, best sum, and the left neighbor registers
`default_nettype none
module gpc_cell (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            clr,
  input  wire                            en,
  input  wire [gpc_pkg::CODE_W-1:0]      code,
  input  wire gpc_pkg::cell_ctl_t        ctl,
  input  wire gpc_pkg::line_entry_t      above,
  output gpc_pkg::line_entry_t           result,
  output logic [gpc_pkg::COUNT_W-1:0]    res_count,
  output logic [gpc_pkg::SUM_W-1:0]      res_sum
);
  import gpc_pkg::*;

  line_entry_t left;

  logic              above_ok;
  logic              left_ok;
  logic [SUM_W:0]    sum_a_raw;
  logic [SUM_W:0]    sum_l_raw;
  logic [SUM_W-1:0]  sum_a;
  logic [SUM_W-1:0]  sum_l;
  logic [COUNT_W:0]  count_raw;
  logic [COUNT_W-1:0] count_mod;

  assign above_ok = ctl.has_above && above.reach && above.code[EXIT_DOWN_BIT];
  assign left_ok  = ctl.has_left && left.reach && left.code[EXIT_RIGHT_BIT];

  assign sum_a_raw = (SUM_W+1)'(above.sum) + (SUM_W+1)'(code);
  assign sum_l_raw = (SUM_W+1)'(left.sum) + (SUM_W+1)'(code);
  assign sum_a = sum_a_raw[SUM_W] ? SUM_LIMIT : sum_a_raw[SUM_W-1:0];
  assign sum_l = sum_l_raw[SUM_W] ? SUM_LIMIT : sum_l_raw[SUM_W-1:0];

  assign count_raw = (above_ok ? (COUNT_W+1)'(above.count) : '0)
                   + (left_ok  ? (COUNT_W+1)'(left.count)  : '0);
  // both terms are below the modulus, so one subtract is enough
  assign count_mod = (count_raw >= COUNT_MOD) ? COUNT_W'(count_raw - COUNT_MOD)
                                              : count_raw[COUNT_W-1:0];

  always_comb begin
    result.code = code;
    if (ctl.first) begin
      result.reach = 1'b1;
      result.count = COUNT_W'(1);
      result.sum   = SUM_W'(code);
    end else begin
      result.reach = above_ok || left_ok;
      result.count = count_mod;
      if (above_ok && left_ok) begin
        result.sum = (sum_l > sum_a) ? sum_l : sum_a;
      end else if (above_ok) begin
        result.sum = sum_a;
      end else if (left_ok) begin
        result.sum = sum_l;
      end else begin
        result.sum = SUM_W'(code);
      end
    end
  end

  assign res_count = result.count;
  assign res_sum   = result.reach ? result.sum : '0;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      left <= '0;
    end else if (en) begin
      left <= result;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/grid_path_count_max_sum_core.sv @@
// top level: raster position tracking, input stage, line store and result register
//
//   channel | signals                          | direction
//   in      | in_valid in_ready cell_code      | cells in raster order
//   out     | out_valid out_ready path_count best_sum | one result per grid
//   cfg     | cfg_valid cfg_ready cfg_data     | grid side, restarts grid
//
// one cell per cycle unless a grid's last cell waits on a held result; a cell
// is registered in the input stage while the line store is read alongside,
// then the update writes the line store, and the result register on a last cell.
// the line store read address is the column of the incoming cell.
// reset and every cfg write restart at the top left cell.
// a held result stalls input once the last cell of the next grid is waiting.
`default_nettype none
module grid_path_count_max_sum_core #(
  parameter int MAX_SIDE = gpc_pkg::MAX_SIDE_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [gpc_pkg::CODE_W-1:0]     cell_code,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [gpc_pkg::COUNT_W-1:0]   path_count,
  output logic [gpc_pkg::SUM_W-1:0]     best_sum,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [gpc_pkg::GRID_W-1:0]     cfg_data
);
  import gpc_pkg::*;

  localparam int POS_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > GRID_W) ? SIDE_W : GRID_W;

  logic [GRID_W-1:0] grid_size;
  logic [CMP_W-1:0]  gs_ext;
  logic [SIDE_W-1:0] side;

  logic [POS_W-1:0]  row_pos;
  logic [POS_W-1:0]  col_pos;
  logic [SIDE_W-1:0] row_inc;
  logic [SIDE_W-1:0] col_inc;
  logic              row_last;
  logic              col_last;

  logic              in_fire;
  logic              cfg_fire;
  logic              s1_valid;
  logic [CODE_W-1:0] s1_code;
  cell_ctl_t         s1_ctl;
  logic              s1_last;
  logic [POS_W-1:0]  s1_col;
  logic              s1_adv;
  logic              out_free;

  cell_ctl_t         in_ctl;
  line_entry_t       above;
  line_entry_t       result;
  logic [COUNT_W-1:0] res_count;
  logic [SUM_W-1:0]  res_sum;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign gs_ext = CMP_W'(grid_size);
  always_comb begin
    if (gs_ext == '0) begin
      side = SIDE_W'(1);
    end else if (gs_ext > CMP_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(gs_ext);
    end
  end

  assign row_inc  = SIDE_W'(row_pos) + SIDE_W'(1);
  assign col_inc  = SIDE_W'(col_pos) + SIDE_W'(1);
  assign row_last = (row_inc == side);
  assign col_last = (col_inc == side);

  assign in_ctl.first     = (row_pos == '0) && (col_pos == '0);
  assign in_ctl.has_above = (row_pos != '0);
  assign in_ctl.has_left  = (col_pos != '0);

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_RESET;
      row_pos   <= '0;
      col_pos   <= '0;
    end else if (cfg_fire) begin
      grid_size <= cfg_data;
      row_pos   <= '0;
      col_pos   <= '0;
    end else if (in_fire) begin
      if (col_last) begin
        col_pos <= '0;
        row_pos <= row_last ? '0 : POS_W'(row_inc);
      end else begin
        col_pos <= POS_W'(col_inc);
      end
    end
  end

  // input stage: cell waits here while the line store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_code <= cell_code;
      s1_ctl  <= in_ctl;
      s1_last <= col_last && row_last;
      s1_col  <= col_pos;
    end
  end

  gpc_line_buf #(
    .DEPTH  (MAX_SIDE),
    .ADDR_W (POS_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_pos),
    .rd_data (above),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (result)
  );

  gpc_cell u_cell (
    .clk       (clk),
    .rst       (rst),
    .clr       (cfg_fire),
    .en        (s1_adv),
    .code      (s1_code),
    .ctl       (s1_ctl),
    .above     (above),
    .result    (result),
    .res_count (res_count),
    .res_sum   (res_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      path_count <= res_count;
      best_sum   <= res_sum;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/grid_path_count_max_sum_checker.sv @@
// channel monitor, path count predictor and result comparison for the grid path count block
`timescale 1ns / 100ps
module grid_path_count_max_sum_checker #(
  parameter int MAX_SIDE = gpc_pkg::MAX_SIDE_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  wire                        in_ready,
  input  wire [gpc_pkg::CODE_W-1:0]  cell_code,
  input  wire                        out_valid,
  input  wire                        out_ready,
  input  wire [gpc_pkg::COUNT_W-1:0] path_count,
  input  wire [gpc_pkg::SUM_W-1:0]   best_sum,
  input  wire                        cfg_valid,
  input  wire                        cfg_ready,
  input  wire [gpc_pkg::GRID_W-1:0]  cfg_data,
  output int unsigned                mismatches,
  output int unsigned                pending
);
  import gpc_pkg::*;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } grid_result_t;

  line_entry_t       row_above [MAX_SIDE];
  line_entry_t       left_cell;
  int unsigned       row_at;
  int unsigned       col_at;
  logic [GRID_W-1:0] side_reg;
  grid_result_t      grid_results [$];

  function automatic int unsigned active_side();
    if (side_reg == '0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return 32'(side_reg);
  endfunction

  function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= COUNT_MOD) t = t - COUNT_MOD;
    return t[COUNT_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                               input logic [CODE_W-1:0] c);
    logic [SUM_W:0] t;
    t = {1'b0, a} + (SUM_W+1)'(c);
    return (t > SUM_LIMIT) ? SUM_LIMIT : t[SUM_W-1:0];
  endfunction

  function automatic void advance_cell(input logic [CODE_W-1:0] code);
    int unsigned      n;
    line_entry_t      here;
    line_entry_t      up;
    logic [SUM_W-1:0] from_left;
    grid_result_t     done;
    n = active_side();
    if (row_at >= n || col_at >= n) begin
      row_at = 0;
      col_at = 0;
    end
    here = '0;
    here.code = code;
    if (row_at == 0 && col_at == 0) begin
      here.reach = 1'b1;
      here.count = COUNT_W'(1);
      here.sum = SUM_W'(code);
    end else begin
      up = row_above[col_at];
      if (row_at > 0 && up.reach && up.code[EXIT_DOWN_BIT]) begin
        here.reach = 1'b1;
        here.count = up.count;
        here.sum = sat_sum(up.sum, code);
      end
      if (col_at > 0 && left_cell.reach && left_cell.code[EXIT_RIGHT_BIT]) begin
        from_left = sat_sum(left_cell.sum, code);
        here.count = mod_add(here.count, left_cell.count);
        if (!here.reach || from_left > here.sum) here.sum = from_left;
        here.reach = 1'b1;
      end
    end
    // unreached cells still carry their own value as sum
    if (!here.reach) begin
      here.count = '0;
      here.sum = SUM_W'(code);
    end
    row_above[col_at] = here;
    left_cell = here;
    if (col_at + 1 < n) begin
      col_at++;
    end else begin
      col_at = 0;
      if (row_at + 1 < n) begin
        row_at++;
      end else begin
        row_at = 0;
        done.count = here.count;
        done.sum = here.reach ? here.sum : '0;
        grid_results.insert(grid_results.size(), done);
      end
    end
  endfunction

  always @(posedge clk) begin
    grid_result_t want;
    if (rst) begin
      foreach (row_above[i]) row_above[i] = '0;
      left_cell = '0;
      row_at = 0;
      col_at = 0;
      side_reg = GRID_RESET;
      grid_results.delete();
      mismatches = 0;
    end else begin
      // a size write restarts the grid at the top left
      if (cfg_valid && cfg_ready) begin
        side_reg = cfg_data;
        row_at = 0;
        col_at = 0;
        left_cell = '0;
      end
      if (in_valid && in_ready) advance_cell(cell_code);
      if (out_valid && out_ready) begin
        if (grid_results.size() == 0) begin
          $error("unexpected transaction: path_count %0d best_sum %0d", path_count, best_sum);
          mismatches++;
        end else begin
          want = grid_results.pop_front();
          if (path_count !== want.count) begin
            $error("path_count mismatch: expected %0d, actual %0d", want.count, path_count);
            mismatches++;
          end
          if (best_sum !== want.sum) begin
            $error("best_sum mismatch: expected %0d, actual %0d", want.sum, best_sum);
            mismatches++;
          end
        end
      end
    end
    pending = grid_results.size();
  end

endmodule

@@ tb/sv/grid_path_count_max_sum_core_test.sv @@
// stimulus, clock, reset, watchdog and verdict for the grid path count block
`timescale 1ns / 100ps
module grid_path_count_max_sum_core_test;
  import gpc_pkg::*;

  localparam logic [CODE_W-1:0] CELL_BLOCK = 2'd0;
  localparam logic [CODE_W-1:0] CELL_RIGHT = 2'd1;
  localparam logic [CODE_W-1:0] CELL_DOWN  = 2'd2;
  localparam logic [CODE_W-1:0] CELL_BOTH  = 2'd3;

  localparam int RANDOM_CELLS   = 380;
  localparam int OPEN_SIDE      = 16;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CODE_W-1:0]  cell_code = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COUNT_W-1:0] path_count;
  logic [SUM_W-1:0]   best_sum;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [GRID_W-1:0]  cfg_data = '0;

  logic        no_idle = 1'b0;
  logic        pressure_go = 1'b0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned quiet_cycles = 0;

  grid_path_count_max_sum_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cell_code (cell_code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .path_count(path_count),
    .best_sum  (best_sum),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  grid_path_count_max_sum_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cell_code (cell_code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .path_count(path_count),
    .best_sum  (best_sum),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit idle_roll();
    return !no_idle && $urandom_range(99) < 19;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(input bit biased);
    if (biased && $urandom_range(99) < 65) return CELL_BOTH;
    return CODE_W'($urandom_range(3));
  endfunction

  // called at a rising edge; valid stays up when cells follow back to back
  task automatic send_cell(input logic [CODE_W-1:0] code);
    if (idle_roll()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (idle_roll());
    end
    in_valid <= 1'b1;
    cell_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // cells that make no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid(input logic [GRID_W-1:0] side);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= side;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    bit pressure_done;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !pressure_done) begin
        pressure_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= no_idle || $urandom_range(99) >= 19;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL grid_path_count_max_sum_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned       sent;
    int unsigned       n;
    int unsigned       grids;
    int unsigned       r;
    logic [GRID_W-1:0] side;
    bit                biased;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // partial grid at the reset size, then a write restarts it
    send_cell(CELL_BOTH);
    send_cell(CELL_RIGHT);

    // zero size runs as one cell per grid
    write_grid('0);
    send_cell(CELL_BLOCK);
    send_cell(CELL_RIGHT);
    send_cell(CELL_DOWN);
    send_cell(CELL_BOTH);

    write_grid(GRID_W'(2));
    repeat (4) send_cell(CELL_BOTH);
    // blocked start leaves the corner unreached
    send_cell(CELL_BLOCK);
    repeat (3) send_cell(CELL_BOTH);
    send_cell(CELL_RIGHT);
    send_cell(CELL_DOWN);
    send_cell(CELL_BOTH);
    send_cell(CELL_BOTH);

    write_grid(GRID_W'(3));
    repeat (4) send_cell(CELL_BOTH);
    send_cell(CELL_BLOCK);
    repeat (4) send_cell(CELL_BOTH);

    // output held off while single cell grids keep coming
    write_grid(GRID_W'(1));
    pressure_go <= 1'b1;
    repeat (24) send_cell(pick_code(1'b0));

    sent = 0;
    while (sent < RANDOM_CELLS) begin
      r = $urandom_range(99);
      if (r < 5) side = '0;
      else if (r < 10) side = GRID_W'($urandom_range(65, 127));
      else if (r < 25) side = GRID_W'($urandom_range(13, 16));
      else side = GRID_W'($urandom_range(1, 12));
      n = (side == '0) ? 1 : ((side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side);
      write_grid(side);
      if (n == MAX_SIDE_DEF) begin
        // oversized setting: only a broken start, cut short by the next write
        repeat ($urandom_range(1, 40)) begin
          send_cell(pick_code(1'b1));
          sent++;
        end
      end else begin
        grids = (n > 12) ? 1 : $urandom_range(1, 3);
        repeat (grids) begin
          biased = $urandom_range(3) != 0;
          repeat (n * n) begin
            send_cell(pick_code(biased));
            sent++;
          end
        end
        if (n > 1 && $urandom_range(3) == 0) begin
          repeat ($urandom_range(1, n * n - 1)) begin
            send_cell(pick_code(1'b1));
            sent++;
          end
        end
      end
    end

    // grid with every exit open, sent and taken with no idling
    write_grid(GRID_W'(OPEN_SIDE));
    no_idle <= 1'b1;
    repeat (OPEN_SIDE * OPEN_SIDE) send_cell(CELL_BOTH);
    drain();
    no_idle <= 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("PASS grid_path_count_max_sum_core");
    end else begin
      $display("FAIL grid_path_count_max_sum_core");
    end
    $finish;
  end

endmodule
